>>> design/julian_date_to_calendar_defines.svh
// Assertion macros for the calendar conversion RTL.
`ifndef JULIAN_DATE_TO_CALENDAR_DEFINES_SVH
`define JULIAN_DATE_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define JDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define JDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/jdc_pkg.sv
// Constants and helper function for the Julian date to calendar converter.
package jdc_pkg;

    localparam int JD_W          = 39;
    localparam int SUM_W         = JD_W + 1;
    localparam int YEAR_W        = 16;
    localparam int MONTH_W       = 4;
    localparam int DAY_W         = 5;
    localparam int FRAC_OUT_W    = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Day number kept at least this wide so the Gregorian terms always fit.
    localparam int Z_MIN_W       = 24;

    localparam int unsigned GREG_START = 2299161;
    localparam int unsigned ALPHA_OFS  = 7468865;
    localparam int unsigned ALPHA_DEN  = 146097;
    localparam int unsigned B_OFS      = 1524;
    localparam int unsigned C_OFS      = 2442;
    localparam int unsigned C_DEN      = 7305;
    localparam int unsigned D_MUL      = 1461;
    localparam int unsigned E_MUL      = 10000;
    localparam int unsigned E_DEN      = 306001;
    localparam int unsigned YEAR_OFS_MAR = 4716;
    localparam int unsigned YEAR_OFS_JAN = 4715;
    localparam int unsigned MONTH_WRAP   = 14;

    // B - D lies in 123..488; E lies in 4..15.
    localparam int BD_W = 9;
    localparam int E_W  = 4;
    localparam int NE_W = 23;

    // floor(30.6001 * e)
    function automatic logic [BD_W-1:0] month_start(input logic [E_W-1:0] e);
        logic [BD_W-1:0] r;
        unique case (e)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd428;
            default: r = 9'd459;
        endcase
        return r;
    endfunction

endpackage

>>> design/julian_date_to_calendar.sv
// Julian date to calendar date converter (Meeus), deep pipeline top level.
//
//  channel | direction | words                        | handshake
//  s_      | in        | s_julian_date                | s_valid / s_ready
//  m_      | out       | m_year_number, m_month_number| m_valid / m_ready
//          |           | m_day_of_month, m_day_fraction|
//
// Cycles: one word enters per cycle unless a waiting output word stalls the
//   pipe; the stages are the three two-stage constant dividers (alpha, C, E)
//   plus the split, sum, D, B-D and output stages between them.
// Reset: aresetn (synchronous, active low) clears the stage valid bits only.
// Stalls: the whole pipe advances when the output stage is empty or taken;
//   s_ready = !m_valid | m_ready, so a waiting output word freezes every
//   stage, bubbles included.

`include "julian_date_to_calendar_defines.svh"

module julian_date_to_calendar #(
    parameter int FRAC_BITS = jdc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [jdc_pkg::JD_W-1:0]             s_julian_date,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [jdc_pkg::YEAR_W-1:0]    m_year_number,
    output logic [jdc_pkg::MONTH_W-1:0]          m_month_number,
    output logic [jdc_pkg::DAY_W-1:0]            m_day_of_month,
    output logic [jdc_pkg::FRAC_OUT_W-1:0]       m_day_fraction
);

    import jdc_pkg::*;

    // ---- widths ------------------------------------------------------------
    localparam int ZR_W  = SUM_W - FRAC_BITS;               // raw day number bits
    localparam int Z_W   = (ZR_W > Z_MIN_W) ? ZR_W : Z_MIN_W;
    localparam int NA_W  = Z_W + 2;                         // 4z - ofs
    localparam int QA_W  = NA_W - 17;                       // alpha
    localparam int B_W   = Z_W + 1;                         // A, B
    localparam int NC_W  = B_W + 5;                         // 20B - ofs
    localparam int QC_W  = NC_W - 12;                       // C
    localparam int DP_W  = QC_W + 11;                       // 1461 C
    localparam int DEPTH = 11;

    // ---- pipeline control --------------------------------------------------
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             adv;

    assign adv      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready  = adv;
    assign m_valid  = vld_reg[DEPTH-1];
    assign vld_next = adv ? {vld_reg[DEPTH-2:0], s_valid} : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---- stage 1: half-day shift, split into day number and fraction --------
    logic [SUM_W-1:0]      sum_in;
    logic [Z_W-1:0]        z_in;
    logic [FRAC_OUT_W-1:0] frac_in;

    assign sum_in = {1'b0, s_julian_date} + (SUM_W'(1) << (FRAC_BITS - 1));
    assign z_in   = Z_W'(sum_in[SUM_W-1:FRAC_BITS]);

    generate
        if (FRAC_BITS >= FRAC_OUT_W) begin : g_frac_trunc
            assign frac_in = sum_in[FRAC_BITS-1 -: FRAC_OUT_W];
        end else begin : g_frac_pad
            assign frac_in = {sum_in[FRAC_BITS-1:0], {(FRAC_OUT_W-FRAC_BITS){1'b0}}};
        end
    endgenerate

    logic [Z_W-1:0]        z1_reg, z2_reg, z3_reg;
    logic                  g1_reg, g2_reg, g3_reg;
    logic [FRAC_OUT_W-1:0] f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg;
    logic [FRAC_OUT_W-1:0] f7_reg, f8_reg, f9_reg, f10_reg;

    // ---- stages 2-3: alpha = floor((4z - 7468865) / 146097) -----------------
    logic [NA_W-1:0] alpha_num;
    logic [QA_W-1:0] alpha;

    assign alpha_num = {z1_reg, 2'b00} - NA_W'(ALPHA_OFS);

    jdc_const_div #(
        .NUM_W (NA_W),
        .DEN   (ALPHA_DEN),
        .Q_W   (QA_W)
    ) u_div_alpha (
        .aclk (aclk),
        .en   (adv),
        .num  (alpha_num),
        .quo  (alpha)
    );

    // ---- stage 4: A and B ---------------------------------------------------
    // Gregorian: A = z + 1 + alpha - floor(alpha/4); Julian: A = z
    logic [B_W-1:0] a_val;
    logic [B_W-1:0] b_next;
    logic [B_W-1:0] b4_reg, b5_reg, b6_reg, b7_reg;

    assign a_val  = g3_reg ? (B_W'(z3_reg) + B_W'(1) + B_W'(alpha) - B_W'(alpha >> 2))
                           : B_W'(z3_reg);
    assign b_next = a_val + B_W'(B_OFS);

    // ---- stages 5-6: C = floor((20B - 2442) / 7305) -------------------------
    logic [NC_W-1:0] c_num;
    logic [QC_W-1:0] c_val;

    assign c_num = NC_W'({b4_reg, 4'b0000}) + NC_W'({b4_reg, 2'b00}) - NC_W'(C_OFS);

    jdc_const_div #(
        .NUM_W (NC_W),
        .DEN   (C_DEN),
        .Q_W   (QC_W)
    ) u_div_c (
        .aclk (aclk),
        .en   (adv),
        .num  (c_num),
        .quo  (c_val)
    );

    // ---- stage 7: D = floor(1461 C / 4) ---------------------------------------
    logic [DP_W-1:0] d_prod;
    logic [B_W-1:0]  d7_reg;
    logic [QC_W-1:0] c7_reg, c8_reg, c9_reg, c10_reg;

    assign d_prod = DP_W'(c_val) * DP_W'(D_MUL);

    // ---- stage 8: B - D and its scaled form ---------------------------------
    // only the low bits of B - D matter: the true value is 123..488
    logic [B_W-1:0]  bd_full;
    logic [BD_W-1:0] bd_val;
    logic [NE_W-1:0] ne_next;
    logic [NE_W-1:0] ne8_reg;
    logic [BD_W-1:0] bd8_reg, bd9_reg, bd10_reg;

    assign bd_full = b7_reg - d7_reg;
    assign bd_val  = bd_full[BD_W-1:0];
    assign ne_next = NE_W'(bd_val) * NE_W'(E_MUL);

    // ---- stages 9-10: E = floor(10000 (B - D) / 306001) -----------------------
    logic [E_W-1:0] e_val;

    jdc_const_div #(
        .NUM_W (NE_W),
        .DEN   (E_DEN),
        .Q_W   (E_W)
    ) u_div_e (
        .aclk (aclk),
        .en   (adv),
        .num  (ne8_reg),
        .quo  (e_val)
    );

    // ---- stage 11: day, month, year -----------------------------------------
    logic [MONTH_W-1:0] month_next;
    logic [BD_W-1:0]    day_full;
    logic [YEAR_W-1:0]  year_next;

    assign month_next = (e_val < E_W'(MONTH_WRAP)) ? (e_val - MONTH_W'(1))
                                                   : (e_val - MONTH_W'(13));
    assign day_full   = bd10_reg - month_start(e_val);
    assign year_next  = c10_reg[YEAR_W-1:0] -
                        ((month_next > MONTH_W'(2)) ? YEAR_W'(YEAR_OFS_MAR)
                                                    : YEAR_W'(YEAR_OFS_JAN));

    logic [YEAR_W-1:0]     year_reg;
    logic [MONTH_W-1:0]    month_reg;
    logic [DAY_W-1:0]      day_reg;
    logic [FRAC_OUT_W-1:0] frac_reg;

    // ---- payload registers: no reset, move with the valid bits ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            z1_reg   <= z_in;
            g1_reg   <= (z_in >= Z_W'(GREG_START));
            f1_reg   <= frac_in;

            z2_reg   <= z1_reg;
            g2_reg   <= g1_reg;
            f2_reg   <= f1_reg;
            z3_reg   <= z2_reg;
            g3_reg   <= g2_reg;
            f3_reg   <= f2_reg;

            b4_reg   <= b_next;
            f4_reg   <= f3_reg;

            b5_reg   <= b4_reg;
            f5_reg   <= f4_reg;
            b6_reg   <= b5_reg;
            f6_reg   <= f5_reg;

            d7_reg   <= B_W'(d_prod >> 2);
            c7_reg   <= c_val;
            b7_reg   <= b6_reg;
            f7_reg   <= f6_reg;

            ne8_reg  <= ne_next;
            bd8_reg  <= bd_val;
            c8_reg   <= c7_reg;
            f8_reg   <= f7_reg;

            bd9_reg  <= bd8_reg;
            c9_reg   <= c8_reg;
            f9_reg   <= f8_reg;
            bd10_reg <= bd9_reg;
            c10_reg  <= c9_reg;
            f10_reg  <= f9_reg;

            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_full[DAY_W-1:0];
            frac_reg  <= f10_reg;
        end
    end

    assign m_year_number  = signed'(year_reg);
    assign m_month_number = month_reg;
    assign m_day_of_month = day_reg;
    assign m_day_fraction = frac_reg;

    // ---- assertions ---------------------------------------------------------
    `JDC_ASSERT_NOW(a_month_range, m_valid, (m_month_number >= 4'd1) && (m_month_number <= 4'd12), "month out of range")
    `JDC_ASSERT_NOW(a_day_range, m_valid, m_day_of_month != 5'd0, "day of month is zero")
    `JDC_ASSERT_NOW(a_stall_only_on_full_out, !s_ready, m_valid && !m_ready, "pipe stalled without a blocked output")
    `JDC_ASSERT_NEXT(a_out_taken_advances, s_valid && s_ready, vld_reg[0], "accepted word not in first stage")

endmodule

>>> design/jdc_const_div.sv
// Two-stage pipelined floor division by a constant (reciprocal multiply, one correction).
module jdc_const_div #(
    parameter int          NUM_W = 26,
    parameter int unsigned DEN   = 7,
    parameter int          Q_W   = 9
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    output logic [Q_W-1:0]   quo
);

    // floor(2^NUM_W / DEN) underestimates the quotient by at most one
    localparam logic [63:0] RECIP = (64'd1 << NUM_W) / 64'(DEN);
    localparam int M_W = NUM_W - $clog2(DEN) + 1;
    localparam int P_W = NUM_W + M_W;
    localparam logic [NUM_W-1:0] DEN_V = NUM_W'(DEN);

    logic [P_W-1:0]   prod_reg;
    logic [NUM_W-1:0] num_reg;
    logic [Q_W-1:0]   quo_reg;

    logic [M_W-1:0]   q_est;
    logic [P_W-1:0]   back;
    logic [NUM_W-1:0] rem;
    logic [M_W:0]     q_full;

    assign q_est  = prod_reg[P_W-1:NUM_W];
    assign back   = P_W'(q_est) * P_W'(DEN);
    assign rem    = num_reg - back[NUM_W-1:0];
    assign q_full = {1'b0, q_est} + (M_W+1)'(rem >= DEN_V);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= P_W'(num) * P_W'(RECIP[M_W-1:0]);
            num_reg  <= num;
            quo_reg  <= Q_W'(q_full);
        end
    end

    assign quo = quo_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the Julian date to calendar date converter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jdc_pkg::*;

    // The block is built at its default fraction width; the stimulus table
    // assumes 16 fraction bits.
    localparam int FRAC_BITS = FRAC_BITS_DEF;

    // Run shape.
    localparam int RANDOM_WORDS = 1050;
    localparam int TAIL_WORDS   = 150;    // last words go without any idling
    localparam int HOLD_AT      = 400;    // word count that starts the long output hold
    localparam int HOLD_CYCLES  = 80;     // well past the 11-stage pipe depth
    localparam int DRAIN_CYCLES = 24;     // extra watch for stray words once every word is back
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int REPORT_MAX   = 10;

    // One result word, in port order.
    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [FRAC_OUT_W-1:0]    frac;
    } cal_date_t;

    // Directed stimulus row: typed rows carry their own answer, the rest
    // go through the predictor.
    typedef struct {
        logic [JD_W-1:0] jd;
        bit              typed;
        cal_date_t       want;
    } stim_row_t;

    localparam int NUM_ROWS   = 17;
    localparam int ALL_WORDS  = NUM_ROWS + RANDOM_WORDS;

    stim_row_t dir_rows [NUM_ROWS] = '{
        // Day zero at noon: first day of the count, half a day in.
        '{{23'd0, 16'h0000},       1'b1, '{-16'sd4712, 4'd1, 5'd1, 16'h8000}},
        // Day zero plus a half: rolls to the next midnight.
        '{{23'd0, 16'h8000},       1'b1, '{-16'sd4712, 4'd1, 5'd2, 16'h0000}},
        // Standard epoch, noon on the first of January 2000.
        '{{23'd2451545, 16'h0000}, 1'b1, '{16'sd2000, 4'd1, 5'd1, 16'h8000}},
        // First Gregorian day, midnight.
        '{{23'd2299160, 16'h8000}, 1'b1, '{16'sd1582, 4'd10, 5'd15, 16'h0000}},
        // Last Julian day, midnight.
        '{{23'd2299159, 16'h8000}, 1'b1, '{16'sd1582, 4'd10, 5'd4, 16'h0000}},
        // Largest input: top of the year range.
        '{{23'h7FFFFF, 16'hFFFF},  1'b0, '0},
        // Last tick before the first midnight.
        '{{23'd0, 16'h7FFF},       1'b0, '0},
        // Last tick of the Julian calendar.
        '{{23'd2299160, 16'h7FFF}, 1'b0, '0},
        // Leap day 2000, then the day after.
        '{{23'd2451603, 16'h8000}, 1'b0, '0},
        '{{23'd2451604, 16'h8000}, 1'b0, '0},
        // 1900 is no Gregorian leap year.
        '{{23'd2415079, 16'h8000}, 1'b0, '0},
        // Last tick of 1999.
        '{{23'd2451544, 16'h7FFF}, 1'b0, '0},
        // Alternating bit patterns, then the largest day count at noon.
        '{{23'h555555, 16'h5555},  1'b0, '0},
        '{{23'h2AAAAA, 16'hAAAA},  1'b0, '0},
        '{{23'h7FFFFF, 16'h0000},  1'b0, '0},
        // Near the start of the common era, Julian side, then the top day-number bit alone.
        '{{23'd1721423, 16'h8000}, 1'b0, '0},
        '{{23'h400000, 16'h8001},  1'b0, '0}
    };

    // DUT ports; every input starts at a known level.
    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic [JD_W-1:0]           s_julian_date = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic signed [YEAR_W-1:0]  m_year_number;
    logic [MONTH_W-1:0]        m_month_number;
    logic [DAY_W-1:0]          m_day_of_month;
    logic [FRAC_OUT_W-1:0]     m_day_fraction;

    // Scoreboard state. The word and stall counters are written with NBAs so that every process
    // reading them at a clock edge sees the pre-edge value.
    cal_date_t expected_dates [$];
    cal_date_t want_date;
    cal_date_t got_date;
    int        words_in       = 0;
    int        words_out      = 0;
    int        input_stalls   = 0;
    int        mismatch_count = 0;
    int        idle_cycles    = 0;

    wire quiet_tail = (words_in >= ALL_WORDS - TAIL_WORDS);

    julian_date_to_calendar #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_julian_date (s_julian_date),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_year_number (m_year_number),
        .m_month_number(m_month_number),
        .m_day_of_month(m_day_of_month),
        .m_day_fraction(m_day_fraction)
    );

    // 2 ns clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Meeus conversion in exact integer form. The date is shifted by half a
    // day, split into day number and fraction, then run through the calendar
    // terms; the Gregorian correction only applies from the switch day on.
    function automatic cal_date_t meeus_calendar(input logic [JD_W-1:0] jd);
        longint unsigned sum, day_num, frac, frac16;
        longint unsigned alpha, a, b, c, d, e, dom, mon;
        longint          yr;
        cal_date_t       r;
        sum     = jd;
        sum     = sum + (64'd1 << (FRAC_BITS - 1));
        day_num = sum >> FRAC_BITS;
        frac    = sum & ((64'd1 << FRAC_BITS) - 64'd1);
        if (FRAC_BITS >= 16) begin
            frac16 = frac >> (FRAC_BITS - 16);
        end else begin
            frac16 = frac << (16 - FRAC_BITS);
        end
        if (day_num < 64'd2299161) begin
            a = day_num;
        end else begin
            alpha = (64'd4 * day_num - 64'd7468865) / 64'd146097;
            a     = day_num + 64'd1 + alpha - alpha / 64'd4;
        end
        b   = a + 64'd1524;
        c   = (64'd20 * b - 64'd2442) / 64'd7305;
        d   = (64'd1461 * c) / 64'd4;
        e   = (64'd10000 * (b - d)) / 64'd306001;
        dom = b - d - (64'd306001 * e) / 64'd10000;
        mon = (e < 64'd14) ? e - 64'd1 : e - 64'd13;
        yr  = (mon > 64'd2) ? longint'(c) - 4716 : longint'(c) - 4715;
        r.year  = yr[YEAR_W-1:0];
        r.month = mon[MONTH_W-1:0];
        r.day   = dom[DAY_W-1:0];
        r.frac  = frac16[FRAC_OUT_W-1:0];
        return r;
    endfunction

    // Random date: mostly anywhere in the field, the rest clustered on the
    // calendar switch, the modern era and both ends of the range.
    function automatic logic [JD_W-1:0] pick_date();
        longint unsigned days, v;
        logic [63:0]     raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            6: begin
                days = GREG_START - 2000 + $urandom_range(0, 4000);
                v    = (days << 16) + $urandom_range(0, 65535);
            end
            7: begin
                days = 2400000 + $urandom_range(0, 110000);
                v    = (days << 16) + $urandom_range(0, 65535);
            end
            8: begin
                days = $urandom_range(0, 4000);
                v    = (days << 16) + $urandom_range(0, 65535);
            end
            9: begin
                days = $urandom_range(0, 4000);
                v    = ((64'd1 << JD_W) - 64'd1) - (days << 16) - $urandom_range(0, 65535);
            end
            default: v = raw;
        endcase
        return v[JD_W-1:0];
    endfunction

    // Offer one word, optionally after a random idle burst, and hold it until
    // taken. The expectation is queued at the accepting edge.
    task automatic offer_word(input logic [JD_W-1:0] jd, input bit typed,
                              input cal_date_t fixed);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_julian_date <= jd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_dates.push_back(typed ? fixed : meeus_calendar(jd));
        words_in <= words_in + 1;
    endtask

    // Stimulus and end of run.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table first, then the random stream.
        for (int i = 0; i < NUM_ROWS; i++) begin
            offer_word(dir_rows[i].jd, dir_rows[i].typed, dir_rows[i].want);
        end
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            offer_word(pick_date(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Let the pipe empty, then watch a while longer for stray words.
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d directed and %0d random dates, %0d words returned",
                 NUM_ROWS, RANDOM_WORDS, words_out);
        $display("input held back for %0d cycles by output back-pressure, %0d mismatches",
                 input_stalls, mismatch_count);
        if (mismatch_count == 0 && expected_dates.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Result side: random stall bursts and ready runs, one long hold once the
    // pipe has seen enough words, and a steady ready through the tail.
    initial begin
        bit held_off;
        held_off = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_off && words_in >= HOLD_AT) begin
                // Long hold: the pipe fills and s_ready drops while the
                // sender keeps offering.
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Output checker: every word taken is compared with the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_ready) begin
                input_stalls <= input_stalls + 1;
            end
            if (m_valid && m_ready) begin
                words_out <= words_out + 1;
                got_date = {m_year_number, m_month_number, m_day_of_month, m_day_fraction};
                if (expected_dates.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("unexpected word: year %0d month %0d day %0d frac %h",
                                 got_date.year, got_date.month, got_date.day, got_date.frac);
                    end
                end else begin
                    want_date = expected_dates.pop_front();
                    if (got_date.year !== want_date.year || got_date.month !== want_date.month ||
                        got_date.day !== want_date.day || got_date.frac !== want_date.frac) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("mismatch at word %0d: want %0d-%0d-%0d frac %h, got %0d-%0d-%0d frac %h",
                                     words_out, want_date.year, want_date.month,
                                     want_date.day, want_date.frac, got_date.year,
                                     got_date.month, got_date.day, got_date.frac);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: any cycle with a handshake on either side counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

endmodule

>>> sim.f
+incdir+design
design/jdc_pkg.sv
design/jdc_const_div.sv
design/julian_date_to_calendar.sv
tb/testbench.sv
